// ===== hw/rtl/wmjc_pkg.sv =====
// ----------------------------------------------------------------------------
// wmjc_pkg
// shared types and constants for the window min jump cost core
// ----------------------------------------------------------------------------
package wmjc_pkg;

  localparam int COST_W   = 32;
  localparam int WINDOW_W = 8;

  localparam logic [COST_W-1:0] COST_TOP = '1;

  typedef logic [COST_W-1:0]   cost_t;
  typedef logic [WINDOW_W-1:0] window_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

endpackage

// ===== hw/rtl/window_min_jump_cost_core.sv =====
// ----------------------------------------------------------------------------
// window_min_jump_cost_core
// least cost to reach each stone of a stream, looking back up to window_k
// stones of the same path through height and cost ring memories
// ----------------------------------------------------------------------------
// One word in gives one word out. For each word, k predecessors are read, where
// k is window_k (zero taken as one, capped at WINDOW_MAX) limited to the number
// of stones already in the current path; the first stone of a path, with
// nothing to look back at, is given cost zero with no reads at all. The
// ring memories have a single read port, so the predecessors are read one per
// cycle and a read-to-compare pipe of two stages follows. The next word is
// taken once the result is in the output register, while that result waits.
// ----------------------------------------------------------------------------
module window_min_jump_cost_core #(
  parameter int WINDOW_MAX  = 128,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          window_k_wr,
  input  wmjc_pkg::window_t             window_k,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [HEIGHT_BITS-1:0]        height,
  input  logic                          last_stone,
  output logic                          out_valid,
  input  logic                          out_ready,
  output wmjc_pkg::cost_t               min_cost,
  output logic                          is_final
);

  localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int KW    = (CNT_W > wmjc_pkg::WINDOW_W) ? CNT_W : wmjc_pkg::WINDOW_W;
  localparam int SUM_W = wmjc_pkg::COST_W + 1;

  logic [HEIGHT_BITS-1:0] height_mem [WINDOW_MAX];
  wmjc_pkg::cost_t        cost_mem   [WINDOW_MAX];

  wmjc_pkg::state_t       state;
  wmjc_pkg::window_t      window_reg;
  logic [CNT_W-1:0]       fill_count;
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_addr;
  logic [CNT_W-1:0]       left;
  logic [HEIGHT_BITS-1:0] cur_h;
  logic                   cur_last;
  wmjc_pkg::cost_t        best;
  logic                   v1;
  logic                   v2;
  logic [HEIGHT_BITS-1:0] rd_h;
  wmjc_pkg::cost_t        rd_c;
  wmjc_pkg::cost_t        cand;

  logic                   in_fire;
  logic                   done_fire;
  logic                   issue;
  logic [KW-1:0]          k_win;
  logic [KW-1:0]          k_cap;
  logic [KW-1:0]          k_eff;
  logic [HEIGHT_BITS-1:0] diff;
  logic [SUM_W-1:0]       sum;

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] a);
    ptr_dec = (a == '0) ? PTR_W'(WINDOW_MAX - 1) : a - PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] a);
    ptr_inc = (a == PTR_W'(WINDOW_MAX - 1)) ? '0 : a + PTR_W'(1);
  endfunction

  assign in_ready  = (state == wmjc_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign done_fire = (state == wmjc_pkg::S_DONE) && (!out_valid || out_ready);
  assign issue     = (state == wmjc_pkg::S_SCAN) && (left != '0);

  // effective window for the word being accepted
  always_comb begin
    k_win = (window_reg == '0) ? KW'(1) : KW'(window_reg);
    k_cap = (k_win > KW'(WINDOW_MAX)) ? KW'(WINDOW_MAX) : k_win;
    k_eff = (k_cap > KW'(fill_count)) ? KW'(fill_count) : k_cap;
  end

  // candidate from the registered read data
  always_comb begin
    diff = (cur_h >= rd_h) ? (cur_h - rd_h) : (rd_h - cur_h);
    sum  = {1'b0, rd_c} + SUM_W'(diff);
  end

  // ring memories
  always_ff @(posedge clk) begin
    if (done_fire) begin
      height_mem[wr_ptr] <= cur_h;
      cost_mem[wr_ptr]   <= best;
    end
    rd_h <= height_mem[rd_addr];
    rd_c <= cost_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    cand <= sum[SUM_W-1] ? wmjc_pkg::COST_TOP : sum[wmjc_pkg::COST_W-1:0];
    if (in_fire) begin
      cur_h    <= height;
      cur_last <= last_stone;
    end
    if (done_fire) begin
      min_cost <= best;
      is_final <= cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= wmjc_pkg::S_IDLE;
      window_reg <= wmjc_pkg::window_t'(1);
      fill_count <= '0;
      wr_ptr     <= '0;
      rd_addr    <= '0;
      left       <= '0;
      best       <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (window_k_wr) begin
        window_reg <= window_k;
      end
      v1 <= issue;
      v2 <= v1;
      if (done_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        wmjc_pkg::S_IDLE: begin
          if (in_fire) begin
            rd_addr <= ptr_dec(wr_ptr);
            left    <= CNT_W'(k_eff);
            if (k_eff == '0) begin
              best  <= '0;
              state <= wmjc_pkg::S_DONE;
            end else begin
              best  <= wmjc_pkg::COST_TOP;
              state <= wmjc_pkg::S_SCAN;
            end
          end
        end
        wmjc_pkg::S_SCAN: begin
          if (issue) begin
            rd_addr <= ptr_dec(rd_addr);
            left    <= left - CNT_W'(1);
          end
          if (v2 && (cand < best)) begin
            best <= cand;
          end
          if (left == '0 && !v1 && !v2) begin
            state <= wmjc_pkg::S_DONE;
          end
        end
        wmjc_pkg::S_DONE: begin
          if (done_fire) begin
            if (cur_last) begin
              fill_count <= '0;
              wr_ptr     <= '0;
            end else begin
              wr_ptr <= ptr_inc(wr_ptr);
              if (fill_count != CNT_W'(WINDOW_MAX)) begin
                fill_count <= fill_count + CNT_W'(1);
              end
            end
            state <= wmjc_pkg::S_IDLE;
          end
        end
        default: begin
          state <= wmjc_pkg::S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(WINDOW_MAX))
    else $error("fill count above window size");

  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    (done_fire && fill_count == '0) |-> best == '0)
    else $error("first stone of a path with nonzero cost");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    done_fire |-> (left == '0 && !v1 && !v2))
    else $error("ring write while reads are in flight");

  a_load_result: assert property (@(posedge clk) disable iff (rst)
    done_fire |=> (out_valid && min_cost == $past(best)))
    else $error("result not loaded into output register");
`endif

endmodule
